// ===== hdl/bps_pkg.sv =====
// Shared types, codes and size helpers for the bilinear pixel sampler.
// No dependencies; bps_if, bps_front, bps_back, bps_checker and the top level import it.
`default_nettype none

package bps_pkg;

  // Request field widths
  localparam int COL_W      = 8;
  localparam int ROW_W      = 8;
  localparam int PIXIN_W    = 16;
  localparam int POS_W      = 17;
  localparam int SAMPLE_W   = 32;
  localparam int OUT_FRAC   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERPOLATE = 2'd2;

  // Request commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Default sizes
  localparam int DEF_MAX_COLS   = 256;
  localparam int DEF_MAX_ROWS   = 256;
  localparam int DEF_FRAC_BITS  = 8;
  localparam int DEF_PIXEL_BITS = 16;

  // Store is split in four banks by column and row parity
  localparam int NUM_BANKS   = 4;
  localparam int QUEUE_DEPTH = 4;

  // Classified request passed from front to back
  typedef struct packed {
    logic       is_write;
    logic       outside;
    logic [3:0] nbr_ok;    // per bank: neighbor lies inside the image
    logic [1:0] wr_bank;   // {row parity, col parity} of a pixel write
  } bps_ctl_t;

  function automatic int bank_depth(int mc, int mr);
    return ((mc + 1) >> 1) * ((mr + 1) >> 1);
  endfunction

  function automatic int bank_aw(int mc, int mr);
    int d;
    d = bank_depth(mc, mr);
    return (d > 1) ? $clog2(d) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bps_if.sv =====
// Valid/ready channel interfaces for sampler requests and results.
// Depends on bps_pkg for field widths.
`default_nettype none

interface bps_in_if;
  import bps_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [COL_W-1:0]       write_col;
  logic [ROW_W-1:0]       write_row;
  logic [PIXIN_W-1:0]     pixel_value;
  logic signed [POS_W-1:0] x_pos;
  logic signed [POS_W-1:0] y_pos;

  modport source (
    output valid, cmd, write_col, write_row, pixel_value, x_pos, y_pos,
    input  ready
  );
  modport sink (
    input  valid, cmd, write_col, write_row, pixel_value, x_pos, y_pos,
    output ready
  );
endinterface

interface bps_out_if;
  import bps_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;
  logic                outside;

  modport source (
    output valid, sample_value, outside,
    input  ready
  );
  modport sink (
    input  valid, sample_value, outside,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/bilinear_pixel_sampler.sv =====
// Top level of the bilinear pixel sampler: front end, request queue and back end.
// Depends on bps_pkg, bps_if, bps_front, bps_queue, bps_back and bps_ram.
//
// Usage:
//   in_chan carries requests. cmd = write stores pixel_value at
//   (write_col, write_row); writes beyond the store are dropped and no
//   request of that kind returns a result. cmd = sample returns one result
//   on out_chan: the bilinear blend (interpolate = 1) or the nearest pixel
//   (interpolate = 0) at (x_pos, y_pos), with 16 fraction bits, or 0 with
//   outside = 1 when the position lies beyond the image.
//   cfg_we/cfg_index/cfg_wdata write image_cols, image_rows, interpolate;
//   write them only while no sample is in flight.
// Timing:
//   One request per cycle sustained while out_chan.ready stays high. A sample
//   passes through the queue, bank read, horizontal weight, vertical weight
//   and output register on its way to out_chan. The four parity banks deliver
//   all four neighbors in a single read, which sets the one-request-per-cycle rate.
// Reset (rst_n low, synchronous): clear the configuration, the queue and all
//   pipeline valids. The pixel store keeps whatever it held; load every pixel
//   a sample touches before sampling it.
// Stall: while out_chan.ready is low the pipeline holds; the 4-entry queue
//   keeps taking requests until it fills, then in_chan.ready drops.
`default_nettype none

module bilinear_pixel_sampler #(
  parameter int MAX_COLS   = bps_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = bps_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS  = bps_pkg::DEF_FRAC_BITS,
  parameter int PIXEL_BITS = bps_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bps_in_if.sink                              in_chan,
  bps_out_if.source                           out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bps_pkg::*;

  localparam int AW = bank_aw(MAX_COLS, MAX_ROWS);
  localparam int WW = FRAC_BITS + 1;
  // Queue entry: control, four bank addresses, weights, write data
  localparam int QW = $bits(bps_ctl_t) + NUM_BANKS * AW + 4 * WW + PIXEL_BITS;

  // Front end outputs
  logic                              f_push;
  bps_ctl_t                          f_ctl;
  logic [NUM_BANKS-1:0][AW-1:0]      f_addr;
  logic [1:0][WW-1:0]                f_wx, f_wy;
  logic [PIXEL_BITS-1:0]             f_wdata;

  // Queue head
  logic                              q_full, q_valid, q_pop;
  logic [QW-1:0]                     q_din, q_dout;
  bps_ctl_t                          q_ctl;
  logic [NUM_BANKS-1:0][AW-1:0]      q_addr;
  logic [1:0][WW-1:0]                q_wx, q_wy;
  logic [PIXEL_BITS-1:0]             q_wdata;

  // Classify each request: write slot or sample with neighbors and weights
  bps_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .q_push    (f_push),
    .q_ctl     (f_ctl),
    .q_addr    (f_addr),
    .q_wx      (f_wx),
    .q_wy      (f_wy),
    .q_wdata   (f_wdata)
  );

  // Keep writes and samples in one queue so each sample sees earlier writes
  assign q_din = {f_ctl, f_addr, f_wx, f_wy, f_wdata};

  bps_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  assign {q_ctl, q_addr, q_wx, q_wy, q_wdata} = q_dout;

  // Execute in order: bank write, or four-bank read and blend
  bps_back #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_ctl    (q_ctl),
    .q_addr   (q_addr),
    .q_wx     (q_wx),
    .q_wy     (q_wy),
    .q_wdata  (q_wdata),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

// ===== hdl/bps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/bps_queue.sv =====
// Short FIFO between the request classifier and the sampling pipeline.
// No dependencies.
`default_nettype none

module bps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic                  valid,
  output logic      [WIDTH-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] slot_r;
  logic [PW-1:0]               wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]               count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  assign full  = (count_r == CW'(DEPTH));
  assign valid = (count_r != '0);
  assign dout  = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== hdl/bps_front.sv =====
// Front end: configuration registers, request acceptance and classification.
// Works out bank addresses, weights and neighbor masks; depends on bps_pkg, bps_if.
`default_nettype none

module bps_front #(
  parameter int MAX_COLS   = bps_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = bps_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS  = bps_pkg::DEF_FRAC_BITS,
  parameter int PIXEL_BITS = bps_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  bps_in_if.sink                               in_chan,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output bps_pkg::bps_ctl_t                    q_ctl,
  output logic [bps_pkg::NUM_BANKS-1:0][bps_pkg::bank_aw(MAX_COLS, MAX_ROWS)-1:0] q_addr,
  output logic [1:0][FRAC_BITS:0]              q_wx,
  output logic [1:0][FRAC_BITS:0]              q_wy,
  output logic [PIXEL_BITS-1:0]                q_wdata
);
  import bps_pkg::*;

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int AW    = bank_aw(MAX_COLS, MAX_ROWS);
  localparam int HC    = (MAX_COLS + 1) >> 1;
  localparam int UW    = POS_W - 1;              // magnitude bits of a position
  localparam int IXW   = POS_W + 1 - FRAC_BITS;  // neighbor index incl. +1
  localparam int WW    = FRAC_BITS + 1;
  localparam int SCALE = 2 ** FRAC_BITS;
  localparam int HALF  = 2 ** (FRAC_BITS - 1);

  logic [CW-1:0] cols_r;
  logic [RW-1:0] rows_r;
  logic          interp_r;

  // Configuration: clamp image size to the store size at write time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= '0;
      rows_r   <= '0;
      interp_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_COLS: begin
          cols_r <= (32'(cfg_wdata) > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cfg_wdata);
        end
        REG_IMAGE_ROWS: begin
          rows_r <= (32'(cfg_wdata) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(cfg_wdata);
        end
        REG_INTERPOLATE: begin
          interp_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  logic [UW-1:0]        ux, uy;
  logic                 x_in, y_in, in_image;
  logic [IXW-1:0]       ix, iy;
  logic [FRAC_BITS-1:0] dx, dy;
  logic [1:0][IXW-1:0]  c_nb, r_nb;    // even / odd parity neighbor
  logic [1:0]           col_ok, row_ok;
  logic                 wr_in_store;
  logic [AW-1:0]        wr_addr;
  logic                 take;

  assign in_chan.ready = !q_full;
  assign take          = in_chan.valid && !q_full;

  always_comb begin
    ux   = in_chan.x_pos[UW-1:0];
    uy   = in_chan.y_pos[UW-1:0];
    x_in = !in_chan.x_pos[POS_W-1] && (32'(ux) <= (32'(cols_r) << FRAC_BITS));
    y_in = !in_chan.y_pos[POS_W-1] && (32'(uy) <= (32'(rows_r) << FRAC_BITS));
    in_image = x_in && y_in;

    // Nearest pixel reuses the blend path with zero fraction
    if (interp_r) begin
      ix = IXW'(ux >> FRAC_BITS);
      iy = IXW'(uy >> FRAC_BITS);
      dx = ux[FRAC_BITS-1:0];
      dy = uy[FRAC_BITS-1:0];
    end else begin
      ix = IXW'((POS_W'(ux) + POS_W'(HALF)) >> FRAC_BITS);
      iy = IXW'((POS_W'(uy) + POS_W'(HALF)) >> FRAC_BITS);
      dx = '0;
      dy = '0;
    end

    c_nb[0] = ix[0] ? ix + IXW'(1) : ix;
    c_nb[1] = ix[0] ? ix : ix + IXW'(1);
    r_nb[0] = iy[0] ? iy + IXW'(1) : iy;
    r_nb[1] = iy[0] ? iy : iy + IXW'(1);

    for (int p = 0; p < 2; p++) begin
      // Nearest pixel uses only the bank of the selected pixel; drop the rest
      col_ok[p] = (32'(c_nb[p]) < 32'(cols_r)) && (interp_r || (ix[0] == 1'(p)));
      row_ok[p] = (32'(r_nb[p]) < 32'(rows_r)) && (interp_r || (iy[0] == 1'(p)));
      // The bank holding the lower neighbor takes the complement weight
      q_wx[p] = (ix[0] == 1'(p)) ? WW'(SCALE) - WW'(dx) : WW'(dx);
      q_wy[p] = (iy[0] == 1'(p)) ? WW'(SCALE) - WW'(dy) : WW'(dy);
    end

    wr_in_store = (32'(in_chan.write_col) < 32'(MAX_COLS)) &&
                  (32'(in_chan.write_row) < 32'(MAX_ROWS));
    wr_addr = AW'(32'(in_chan.write_row[ROW_W-1:1]) * HC +
                  32'(in_chan.write_col[COL_W-1:1]));

    q_ctl.is_write = (in_chan.cmd == CMD_WRITE);
    q_ctl.outside  = !in_image;
    q_ctl.wr_bank  = {in_chan.write_row[0], in_chan.write_col[0]};
    for (int pr = 0; pr < 2; pr++) begin
      for (int pc = 0; pc < 2; pc++) begin
        q_ctl.nbr_ok[pr*2+pc] = in_image && col_ok[pc] && row_ok[pr];
        if (in_chan.cmd == CMD_WRITE) begin
          q_addr[pr*2+pc] = wr_addr;
        end else begin
          q_addr[pr*2+pc] = AW'(32'(r_nb[pr][IXW-1:1]) * HC + 32'(c_nb[pc][IXW-1:1]));
        end
      end
    end

    q_wdata = PIXEL_BITS'(in_chan.pixel_value);
    // Drop writes beyond the store: they change nothing and return nothing
    q_push  = take && ((in_chan.cmd == CMD_SAMPLE) || wr_in_store);
  end

endmodule

`default_nettype wire

// ===== hdl/bps_back.sv =====
// Back end: banked pixel store, neighbor fetch, bilinear blend and result register.
// Depends on bps_pkg, bps_if and bps_ram.
`default_nettype none

module bps_back #(
  parameter int MAX_COLS   = bps_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = bps_pkg::DEF_MAX_ROWS,
  parameter int FRAC_BITS  = bps_pkg::DEF_FRAC_BITS,
  parameter int PIXEL_BITS = bps_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire bps_pkg::bps_ctl_t    q_ctl,
  input  wire logic [bps_pkg::NUM_BANKS-1:0][bps_pkg::bank_aw(MAX_COLS, MAX_ROWS)-1:0] q_addr,
  input  wire logic [1:0][FRAC_BITS:0] q_wx,
  input  wire logic [1:0][FRAC_BITS:0] q_wy,
  input  wire logic [PIXEL_BITS-1:0]   q_wdata,
  bps_out_if.source                 out_chan
);
  import bps_pkg::*;

  localparam int DEPTH = bank_depth(MAX_COLS, MAX_ROWS);
  localparam int WW    = FRAC_BITS + 1;
  localparam int PRW   = PIXEL_BITS + FRAC_BITS;
  localparam int VW    = PIXEL_BITS + 2 * FRAC_BITS;
  localparam int SW    = (VW + OUT_FRAC + 1 > SAMPLE_W + 1) ? VW + OUT_FRAC + 1 : SAMPLE_W + 1;

  logic adv;
  logic [NUM_BANKS-1:0][PIXEL_BITS-1:0] rdata;

  logic                   out_valid_r;
  logic [SAMPLE_W-1:0]    out_value_r;
  logic                   out_outside_r;

  // Advance the whole pipeline unless a result waits at the output
  assign adv   = !out_valid_r || out_chan.ready;
  assign q_pop = adv && q_valid;

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    bps_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (q_pop && q_ctl.is_write && (q_ctl.wr_bank == 2'(b))),
      .waddr (q_addr[b]),
      .wdata (q_wdata),
      .re    (q_pop && !q_ctl.is_write),
      .raddr (q_addr[b]),
      .rdata (rdata[b])
    );
  end

  // Fetch stage: control alongside the registered bank reads
  logic                 b1_valid_r, b1_outside_r;
  logic [3:0]           b1_ok_r;
  logic [1:0][WW-1:0]   b1_wx_r, b1_wy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (adv) begin
      b1_valid_r <= q_pop && !q_ctl.is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_outside_r <= q_ctl.outside;
      b1_ok_r      <= q_ctl.nbr_ok;
      b1_wx_r      <= q_wx;
      b1_wy_r      <= q_wy;
    end
  end

  // Horizontal weight stage
  logic                       b2_valid_r, b2_outside_r;
  logic [NUM_BANKS-1:0][PRW-1:0] prod_nxt, b2_prod_r;
  logic [1:0][WW-1:0]         b2_wy_r;

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      prod_nxt[b] = (b1_ok_r[b] ? PRW'(rdata[b]) : PRW'(0)) * PRW'(b1_wx_r[b % 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
    end else if (adv) begin
      b2_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_outside_r <= b1_outside_r;
      b2_prod_r    <= prod_nxt;
      b2_wy_r      <= b1_wy_r;
    end
  end

  // Vertical weight stage
  logic                  b3_valid_r, b3_outside_r;
  logic [1:0][VW-1:0]    v_nxt, b3_v_r;
  logic [1:0][PRW-1:0]   h;

  always_comb begin
    for (int pr = 0; pr < 2; pr++) begin
      h[pr]     = b2_prod_r[pr*2] + b2_prod_r[pr*2+1];
      v_nxt[pr] = VW'(h[pr]) * VW'(b2_wy_r[pr]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_valid_r <= 1'b0;
    end else if (adv) begin
      b3_valid_r <= b2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_outside_r <= b2_outside_r;
      b3_v_r       <= v_nxt;
    end
  end

  // Sum, rescale to 16 fraction bits, saturate; outside samples give zero
  logic [VW-1:0]       f;
  logic [SW-1:0]       scaled;
  logic [SAMPLE_W-1:0] value_nxt;

  assign f = b3_v_r[0] + b3_v_r[1];

  if (2 * FRAC_BITS > OUT_FRAC) begin : g_round
    localparam int SH = 2 * FRAC_BITS - OUT_FRAC;
    assign scaled = (SW'(f) + (SW'(1) << (SH - 1))) >> SH;
  end else begin : g_widen
    assign scaled = SW'(f) << (OUT_FRAC - 2 * FRAC_BITS);
  end

  always_comb begin
    if (b3_outside_r) begin
      value_nxt = '0;
    end else if (|scaled[SW-1:SAMPLE_W]) begin
      value_nxt = '1;
    end else begin
      value_nxt = scaled[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b3_valid_r) begin
      out_value_r   <= value_nxt;
      out_outside_r <= b3_outside_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.sample_value = out_value_r;
  assign out_chan.outside      = out_outside_r;

endmodule

`default_nettype wire

// ===== hdl/bps_checker.sv =====
// Port-level checks for the bilinear pixel sampler, bound to the top level.
// Depends on bps_pkg and the top-level port list.
`default_nettype none

module bps_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_cmd,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [bps_pkg::SAMPLE_W-1:0] out_sample_value,
  input wire logic                         out_outside
);
  import bps_pkg::*;

  // Sample requests accepted but not yet returned
  logic [3:0] pend_r;
  logic       samp_take, res_take;

  assign samp_take = in_valid && in_ready && (in_cmd == CMD_SAMPLE);
  assign res_take  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(samp_take) - 4'(res_take);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample_value) && $stable(out_outside))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without a pending sample request");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outside |-> out_sample_value == '0)
    else $error("outside result carries a nonzero value");

endmodule

bind bilinear_pixel_sampler bps_checker u_bps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_cmd           (in_chan.cmd),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_sample_value (out_chan.sample_value),
  .out_outside      (out_chan.outside)
);

`default_nettype wire
